@@ rtl/core/pba_pkg.sv @@
// ----------------------------------------------------------------------------
// pba_pkg: shared types and constants of the port bitmap allocator
// Request and response words, request kind and status codes, and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

  localparam int DEF_MAX_WORDS  = 64;
  localparam int DEF_OWNER_BITS = 16;

  localparam int PORT_W   = 16;
  localparam int OWNER_W  = 16;
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;
  localparam int WCOUNT_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [WORD_W-1:0] FULL_WORD = 32'hFFFF_FFFF;

  // request kinds
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;

  // response status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT = 1'd1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [PORT_W-1:0]  port_number;
    logic [OWNER_W-1:0] owner_id;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PORT_W-1:0]  granted_port;
    logic [OWNER_W-1:0] found_owner;
  } rsp_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic exec_fire;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/port_bitmap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// port_bitmap_allocator_unit: next-fit proxy port allocator
// Hands out, releases and looks up ports of a window tracked as a bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready as one word (kind, port_number,
//   owner_id); one response word per request leaves on out_valid/out_ready
//   (status, granted_port, found_owner). Responses keep request order.
//   cfg_valid/cfg_ready writes port_base (index 0) or word_count (index 1);
//   cfg_ready is always high. Write configuration only while the block idles.
//   Each request passes through accept and execute: the accept cycle reads
//   the bitmap word (and the owner entry), chosen by the full-word flag
//   search or by the port offset, and execute does the read-modify-write
//   and loads the output register. One request is in flight at a time, so
//   a new request is taken only once the last one has left execute.
//   After reset the bitmap memory is cleared one word per cycle, MAX_WORDS
//   words in all, with in_ready low; full flags and search start clear at once.
//   If the receiver stalls, the finished word waits in the output register
//   and the next request is taken but held in execute until that word leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module port_bitmap_allocator_unit #(
  parameter int MAX_WORDS  = pba_pkg::DEF_MAX_WORDS,
  parameter int OWNER_BITS = pba_pkg::DEF_OWNER_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire pba_pkg::req_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pba_pkg::rsp_t                        out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pba_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pba_pkg::ctl_cmd_t cmd;
  pba_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pba_dpath #(
    .MAX_WORDS  (MAX_WORDS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

@@ rtl/core/pba_ctrl.sv @@
// ----------------------------------------------------------------------------
// pba_ctrl: request sequencer
// Runs the bitmap clearing pass after reset, then takes one request at a
// time through accept and execute.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output pba_pkg::ctl_cmd_t      cmd,
  input  wire pba_pkg::ctl_sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready      = (state_r == S_IDLE);
  assign cmd.clear_en  = (state_r == S_CLEAR);
  assign cmd.accept    = in_ready && in_valid;
  assign cmd.exec_fire = (state_r == S_EXEC) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      // hold until the output register can take the word
      S_EXEC:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pba_dpath.sv @@
// ----------------------------------------------------------------------------
// pba_dpath: bitmap, owner store and search logic
// Holds the configuration, the used-port bitmap memory with its full-word
// flags, the owner memory, the request registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_dpath #(
  parameter int MAX_WORDS  = pba_pkg::DEF_MAX_WORDS,
  parameter int OWNER_BITS = pba_pkg::DEF_OWNER_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire pba_pkg::req_t                      in_data,
  input  wire logic                               cfg_valid,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pba_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output pba_pkg::rsp_t                           out_data,
  input  wire pba_pkg::ctl_cmd_t                  cmd,
  output pba_pkg::ctl_sts_t                       sts
);

  localparam int WAW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int OFF_W  = WAW + pba_pkg::BIT_W;
  localparam int CNT_W  = $clog2(MAX_WORDS + 1);
  localparam int CMP_W  = (CNT_W > pba_pkg::WCOUNT_W) ? CNT_W : pba_pkg::WCOUNT_W;
  localparam int RW     = (CMP_W + pba_pkg::BIT_W > pba_pkg::PORT_W) ?
                          CMP_W + pba_pkg::BIT_W : pba_pkg::PORT_W;
  localparam int DEPTH  = MAX_WORDS * pba_pkg::WORD_W;

  // configuration
  logic [pba_pkg::PORT_W-1:0]   port_base_r;
  logic [pba_pkg::WCOUNT_W-1:0] word_count_r;

  // allocator state
  logic [WAW-1:0]                search_start_r;
  logic [MAX_WORDS-1:0]          full_r;
  logic [pba_pkg::WORD_W-1:0]    used_mem [MAX_WORDS];
  logic [OWNER_BITS-1:0]         owner_mem [DEPTH];
  logic [WAW-1:0]                clr_addr_r;

  // request registers
  logic [1:0]                    kind_r;
  logic [OWNER_BITS-1:0]         owner_r;
  logic [WAW-1:0]                word_r;
  logic [pba_pkg::BIT_W-1:0]     bit_r;
  logic                          hit_r;
  logic [pba_pkg::WORD_W-1:0]    used_q_r;
  logic [OWNER_BITS-1:0]         owner_q_r;

  logic                          out_valid_r;
  pba_pkg::rsp_t                 out_data_r;

  // window size and search start
  logic [CMP_W-1:0]              n_c;
  logic [CMP_W-1:0]              ss_inc;
  logic [CMP_W-1:0]              start_c;
  logic [MAX_WORDS-1:0]          upper_c;
  logic [MAX_WORDS-1:0]          lower_c;
  logic [WAW-1:0]                up_idx;
  logic [WAW-1:0]                lo_idx;
  logic                          any_free;
  logic [WAW-1:0]                pick_c;

  // range check
  logic [pba_pkg::PORT_W-1:0]    diff_c;
  logic                          in_range_c;
  logic [OWNER_BITS-1:0]         owner_in_c;

  // execute
  logic [pba_pkg::BIT_W-1:0]     low_clear;
  logic [pba_pkg::WORD_W-1:0]    bit_mask;
  logic                          bit_set;
  logic                          is_alloc;
  logic                          is_rel;
  logic                          is_look;
  logic                          alloc_ok;
  logic                          rel_ok;
  logic                          look_ok;
  logic                          used_we;
  logic [pba_pkg::WORD_W-1:0]    used_wd;
  logic [pba_pkg::OWNER_W-1:0]   found_c;
  pba_pkg::rsp_t                 rsp_c;

  assign n_c = (CMP_W'(word_count_r) > CMP_W'(MAX_WORDS)) ?
               CMP_W'(MAX_WORDS) : CMP_W'(word_count_r);
  assign ss_inc  = CMP_W'(search_start_r) + CMP_W'(1);
  assign start_c = (ss_inc >= n_c) ? '0 : ss_inc;

  // next-fit search: first non-full word at or after start, else from word 0
  always_comb begin
    for (int i = 0; i < MAX_WORDS; i++) begin
      lower_c[i] = !full_r[i] && (CMP_W'(i) < n_c);
      upper_c[i] = lower_c[i] && (CMP_W'(i) >= start_c);
    end
  end

  always_comb begin
    up_idx = '0;
    lo_idx = '0;
    for (int i = MAX_WORDS - 1; i >= 0; i--) begin
      if (upper_c[i]) up_idx = WAW'(i);
      if (lower_c[i]) lo_idx = WAW'(i);
    end
  end

  assign any_free = |lower_c;
  assign pick_c   = (|upper_c) ? up_idx : lo_idx;

  assign diff_c     = in_data.port_number - port_base_r;
  assign in_range_c = (in_data.port_number >= port_base_r) &&
                      (RW'(diff_c) < RW'({n_c, {pba_pkg::BIT_W{1'b0}}}));

  generate
    if (OWNER_BITS > pba_pkg::OWNER_W) begin : g_own_wide
      assign owner_in_c = {{(OWNER_BITS - pba_pkg::OWNER_W){1'b0}}, in_data.owner_id};
      assign found_c    = owner_q_r[pba_pkg::OWNER_W-1:0];
    end else if (OWNER_BITS == pba_pkg::OWNER_W) begin : g_own_same
      assign owner_in_c = in_data.owner_id;
      assign found_c    = owner_q_r;
    end else begin : g_own_narrow
      assign owner_in_c = in_data.owner_id[OWNER_BITS-1:0];
      assign found_c    = {{(pba_pkg::OWNER_W - OWNER_BITS){1'b0}}, owner_q_r};
    end
  endgenerate

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_base_r  <= '0;
      word_count_r <= pba_pkg::WCOUNT_W'(64);
    end else if (cfg_valid) begin
      case (cfg_index)
        pba_pkg::CFG_PORT_BASE:  port_base_r  <= cfg_data;
        pba_pkg::CFG_WORD_COUNT: word_count_r <= cfg_data[pba_pkg::WCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture and memory reads on accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= in_data.kind;
      owner_r <= owner_in_c;
      bit_r   <= diff_c[pba_pkg::BIT_W-1:0];
      case (in_data.kind)
        pba_pkg::KIND_ALLOC: begin
          word_r <= pick_c;
          hit_r  <= any_free;
        end
        pba_pkg::KIND_RELEASE, pba_pkg::KIND_LOOKUP: begin
          word_r <= diff_c[OFF_W-1:pba_pkg::BIT_W];
          hit_r  <= in_range_c;
        end
        default: begin
          word_r <= diff_c[OFF_W-1:pba_pkg::BIT_W];
          hit_r  <= 1'b0;
        end
      endcase
      used_q_r  <= used_mem[(in_data.kind == pba_pkg::KIND_ALLOC) ?
                            pick_c : diff_c[OFF_W-1:pba_pkg::BIT_W]];
      owner_q_r <= owner_mem[diff_c[OFF_W-1:0]];
    end
  end

  // lowest clear bit of the fetched word
  always_comb begin
    low_clear = '0;
    for (int b = pba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!used_q_r[b]) low_clear = pba_pkg::BIT_W'(b);
    end
  end

  assign is_alloc = (kind_r == pba_pkg::KIND_ALLOC);
  assign is_rel   = (kind_r == pba_pkg::KIND_RELEASE);
  assign is_look  = (kind_r == pba_pkg::KIND_LOOKUP);
  assign bit_set  = used_q_r[bit_r];
  assign bit_mask = pba_pkg::WORD_W'(1) << (is_alloc ? low_clear : bit_r);
  assign alloc_ok = is_alloc && hit_r;
  assign rel_ok   = is_rel && hit_r && bit_set;
  assign look_ok  = is_look && hit_r && bit_set;
  assign used_we  = alloc_ok || rel_ok;
  assign used_wd  = alloc_ok ? (used_q_r | bit_mask) : (used_q_r & ~bit_mask);

  always_comb begin
    rsp_c = '0;
    case (kind_r)
      pba_pkg::KIND_ALLOC: begin
        rsp_c.status = hit_r ? pba_pkg::ST_OK : pba_pkg::ST_FULL;
        if (hit_r) begin
          rsp_c.granted_port = port_base_r +
                               pba_pkg::PORT_W'({word_r, low_clear});
        end
      end
      pba_pkg::KIND_RELEASE, pba_pkg::KIND_LOOKUP: begin
        if (!hit_r) rsp_c.status = pba_pkg::ST_RANGE;
        else if (!bit_set) rsp_c.status = pba_pkg::ST_NOTFOUND;
        else rsp_c.status = pba_pkg::ST_OK;
        if (look_ok) rsp_c.found_owner = found_c;
      end
      default: rsp_c.status = pba_pkg::ST_RANGE;
    endcase
  end

  // bitmap memory: clearing pass after reset, read-modify-write on execute
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      used_mem[clr_addr_r] <= '0;
    end else if (cmd.exec_fire && used_we) begin
      used_mem[word_r] <= used_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_fire && alloc_ok) begin
      owner_mem[{word_r, low_clear}] <= owner_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r     <= '0;
      full_r         <= '0;
      search_start_r <= '0;
    end else begin
      if (cmd.clear_en) clr_addr_r <= clr_addr_r + WAW'(1);
      if (cmd.exec_fire && used_we) begin
        full_r[word_r] <= (used_wd == pba_pkg::FULL_WORD);
      end
      if (cmd.exec_fire && alloc_ok) search_start_r <= word_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_fire) out_data_r <= rsp_c;
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.clear_last = (clr_addr_r == WAW'(MAX_WORDS - 1));

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the port bitmap allocator
// Drives allocate, release and lookup requests over several window settings.
// A directed opening covers the empty window, a window that wraps past port
// 65535, range errors and double release; random phases then fill and drain
// small and large windows. A scoreboard predicts each response word and
// compares it with what the block returns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WIN_WORDS   = pba_pkg::DEF_MAX_WORDS;
  localparam int PHASE_ITEMS = 130;
  localparam int MAX_REPORTS = 10;

  class port_window_model;
    logic [pba_pkg::WORD_W-1:0]   used_map [WIN_WORDS];
    logic [pba_pkg::OWNER_W-1:0]  owner_of [WIN_WORDS*32];
    int unsigned                  last_word;
    logic [pba_pkg::PORT_W-1:0]   base;
    logic [pba_pkg::WCOUNT_W-1:0] words_cfg;
    pba_pkg::rsp_t                expected_rsp [$];
    int unsigned                  mismatches;
    int unsigned                  status_seen [4];

    function new();
      foreach (used_map[i]) used_map[i] = '0;
      foreach (owner_of[i]) owner_of[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      last_word = 0;
      base = '0;
      words_cfg = pba_pkg::WCOUNT_W'(pba_pkg::DEF_MAX_WORDS);
      mismatches = 0;
    endfunction

    function int unsigned window_words();
      return (words_cfg > WIN_WORDS) ? WIN_WORDS : words_cfg;
    endfunction

    function void write_reg(logic [pba_pkg::CFG_IDX_W-1:0] idx,
                            logic [pba_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        pba_pkg::CFG_PORT_BASE:  base = val;
        pba_pkg::CFG_WORD_COUNT: words_cfg = val[pba_pkg::WCOUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit offset_of(logic [pba_pkg::PORT_W-1:0] port, output int unsigned off);
      int unsigned d;
      off = 0;
      if (port < base) return 1'b0;
      d = port - base;
      if (d >= window_words() * 32) return 1'b0;
      off = d;
      return 1'b1;
    endfunction

    // Note an accepted request word and queue the response it must produce.
    function void take_request(pba_pkg::req_t r);
      pba_pkg::rsp_t e;
      int unsigned   n, w, off, b, k;
      e = '0;
      e.status = pba_pkg::ST_RANGE;
      n = window_words();
      case (r.kind)
        pba_pkg::KIND_ALLOC: begin
          e.status = pba_pkg::ST_FULL;
          // next-fit: begin one word past the last grant, wrap to zero
          w = (last_word + 1 >= n) ? 0 : last_word + 1;
          for (k = 0; k < n && e.status == pba_pkg::ST_FULL; k++) begin
            if (used_map[w] != pba_pkg::FULL_WORD) begin
              b = 0;
              while (used_map[w][b]) b++;
              used_map[w][b] = 1'b1;
              off = w * 32 + b;
              owner_of[off] = r.owner_id;
              last_word = w;
              e.granted_port = pba_pkg::PORT_W'(base + off);
              e.status = pba_pkg::ST_OK;
            end else begin
              w = (w + 1 >= n) ? 0 : w + 1;
            end
          end
        end
        pba_pkg::KIND_RELEASE, pba_pkg::KIND_LOOKUP: begin
          if (offset_of(r.port_number, off)) begin
            w = off >> 5;
            b = off & 31;
            if (!used_map[w][b]) begin
              e.status = pba_pkg::ST_NOTFOUND;
            end else if (r.kind == pba_pkg::KIND_RELEASE) begin
              used_map[w][b] = 1'b0;
              owner_of[off] = '0;
              e.status = pba_pkg::ST_OK;
            end else begin
              e.found_owner = owner_of[off];
              e.status = pba_pkg::ST_OK;
            end
          end
        end
        default: ;
      endcase
      expected_rsp.push_back(e);
    endfunction

    function void note_mismatch(string what, pba_pkg::rsp_t want, pba_pkg::rsp_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%s: expected status %0d port %0d owner %0d, got status %0d port %0d owner %0d",
                 what, want.status, want.granted_port, want.found_owner,
                 got.status, got.granted_port, got.found_owner);
    endfunction

    function void match_response(pba_pkg::rsp_t got);
      pba_pkg::rsp_t want;
      if (!$isunknown(got.status)) status_seen[got.status]++;
      if (expected_rsp.size() == 0) begin
        note_mismatch("response with nothing outstanding", '0, got);
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status || got.granted_port !== want.granted_port ||
          got.found_owner !== want.found_owner)
        note_mismatch("response mismatch", want, got);
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  pba_pkg::req_t                  in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  pba_pkg::rsp_t                  out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pba_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  port_window_model model;
  int          in_gap_pct = 0;
  int          stall_pct = 0;
  int          alloc_pct = 50;
  int          stall_left = 0;
  int unsigned requests_sent = 0;
  int unsigned windows_set = 0;

  logic [pba_pkg::PORT_W-1:0]   win_base [12] = '{16'h0000, 16'h1234, 16'hFFF0, 16'hFFC0,
                                                  16'h0000, 16'h8000, 16'd500, 16'hFFFF,
                                                  16'd40000, 16'h0400, 16'h0000, 16'hABCD};
  logic [pba_pkg::WCOUNT_W-1:0] win_words [12] = '{7'd1, 7'd2, 7'd1, 7'd3, 7'd64, 7'd127,
                                                   7'd0, 7'd4, 7'd100, 7'd2, 7'd1, 7'd5};

  port_bitmap_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function int idle_len(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(negedge clk) begin
    if (stall_left == 0) stall_left = idle_len(stall_pct);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) model.match_response(out_data);
      if (cfg_valid && cfg_ready) model.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) model.take_request(in_data);
    end
  end

  // Called at a falling edge; returns at the falling edge after the accept.
  task send_request(input logic [1:0] kind, input logic [pba_pkg::PORT_W-1:0] port,
                    input logic [pba_pkg::OWNER_W-1:0] owner);
    pba_pkg::req_t r;
    int            gap;
    r.kind = kind;
    r.port_number = port;
    r.owner_id = owner;
    gap = idle_len(in_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_ready !== 1'b1);
    requests_sent++;
    @(negedge clk);
  endtask

  task drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (model.expected_rsp.size() != 0);
  endtask

  task set_window(input logic [pba_pkg::PORT_W-1:0] base_val,
                  input logic [pba_pkg::WCOUNT_W-1:0] words_val);
    cfg_valid <= 1'b1;
    cfg_index <= pba_pkg::CFG_PORT_BASE;
    cfg_data <= base_val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_index <= pba_pkg::CFG_WORD_COUNT;
    cfg_data <= pba_pkg::CFG_DATA_W'(words_val);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    windows_set++;
  endtask

  // Target of a release or lookup: mostly a port in use, sometimes an edge or noise.
  function logic [pba_pkg::PORT_W-1:0] pick_port();
    int unsigned span, off;
    int          sel;
    span = model.window_words() * 32;
    sel = $urandom_range(9);
    if (span == 0 || sel == 0) return pba_pkg::PORT_W'($urandom);
    if (sel == 1) return model.base - 16'd1;
    if (sel == 2) return pba_pkg::PORT_W'(model.base + span);
    off = $urandom_range(span - 1);
    for (int t = 0; t < 8 && sel > 4; t++) begin
      if (model.used_map[off >> 5][off & 31]) return pba_pkg::PORT_W'(model.base + off);
      off = $urandom_range(span - 1);
    end
    return pba_pkg::PORT_W'(model.base + off);
  endfunction

  task random_request();
    logic [1:0] kind;
    int         roll;
    roll = $urandom_range(99);
    if (roll >= 95) kind = KIND_UNUSED;
    else if (roll < alloc_pct) kind = pba_pkg::KIND_ALLOC;
    else if ($urandom_range(99) < 55) kind = pba_pkg::KIND_RELEASE;
    else kind = pba_pkg::KIND_LOOKUP;
    if (kind == pba_pkg::KIND_RELEASE || kind == pba_pkg::KIND_LOOKUP)
      send_request(kind, pick_port(), pba_pkg::OWNER_W'($urandom));
    else
      send_request(kind, pba_pkg::PORT_W'($urandom), pba_pkg::OWNER_W'($urandom));
  endtask

  initial begin
    model = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // hold off until the bitmap clear after reset is done
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    in_gap_pct = 30;
    stall_pct = 10;

    // empty window
    set_window(16'd100, 7'd0);
    send_request(pba_pkg::KIND_ALLOC, 16'd0, 16'h1111);
    send_request(pba_pkg::KIND_RELEASE, 16'd100, 16'h0000);
    send_request(pba_pkg::KIND_LOOKUP, 16'd100, 16'h0000);
    send_request(KIND_UNUSED, 16'hFFFF, 16'hFFFF);
    drain_results();

    // one word near the top of the port space
    set_window(16'hFFF0, 7'd1);
    send_request(pba_pkg::KIND_ALLOC, 16'hFFFF, 16'hFFFF);
    send_request(pba_pkg::KIND_ALLOC, 16'h0000, 16'h0000);
    send_request(pba_pkg::KIND_ALLOC, 16'h1234, 16'h5A5A);
    send_request(pba_pkg::KIND_LOOKUP, 16'hFFF1, 16'hFFFF);
    send_request(pba_pkg::KIND_LOOKUP, 16'hFFF0, 16'h0000);
    send_request(pba_pkg::KIND_LOOKUP, 16'hFFF5, 16'h0000);
    send_request(pba_pkg::KIND_RELEASE, 16'hFFF1, 16'h0000);
    send_request(pba_pkg::KIND_RELEASE, 16'hFFF1, 16'h0000);
    send_request(pba_pkg::KIND_LOOKUP, 16'hFFF1, 16'h0000);
    send_request(pba_pkg::KIND_LOOKUP, 16'hFFEF, 16'h0000);
    send_request(pba_pkg::KIND_LOOKUP, 16'h0000, 16'h0000);
    send_request(pba_pkg::KIND_RELEASE, 16'h0010, 16'h0000);
    send_request(KIND_UNUSED, 16'h0000, 16'h0000);
    send_request(pba_pkg::KIND_ALLOC, 16'h0000, 16'hA5A5);

    for (int p = 0; p < 12; p++) begin
      drain_results();
      set_window(win_base[p], win_words[p]);
      in_gap_pct = (p % 4 == 0) ? 0 : $urandom_range(10, 50);
      stall_pct = (p % 4 == 0) ? 0 : $urandom_range(5, 30);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 32 == 0) begin
          case ($urandom_range(3))
            0: alloc_pct = 85;
            1: alloc_pct = 60;
            2: alloc_pct = 40;
            default: alloc_pct = 20;
          endcase
        end
        if ($urandom_range(59) == 0) drain_results();
        random_request();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d requests over %0d window settings, including empty and wrapping windows",
             requests_sent, windows_set);
    $display("Responses seen: %0d ok, %0d full, %0d out of range, %0d not allocated",
             model.status_seen[pba_pkg::ST_OK], model.status_seen[pba_pkg::ST_FULL],
             model.status_seen[pba_pkg::ST_RANGE], model.status_seen[pba_pkg::ST_NOTFOUND]);
    if (model.mismatches == 0 && model.expected_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("Mismatches: %0d, responses still outstanding: %0d",
               model.mismatches, model.expected_rsp.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d responses outstanding", model.expected_rsp.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
